// File: rtl/tad_pkg.sv
`default_nettype none
package tad_pkg;
  localparam int PIX_W = 8;
  localparam int SUM_W = 20;
  localparam int MAX_TILE_SIDE = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_H  = 2'd3;

  // one tile-finished word headed for the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum_b;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_r;
    logic [12:0]      area;
    logic [9:0]       col;
    logic [11:0]      row;
    logic             last;
  } tile_job_t;
endpackage
`default_nettype wire

// File: rtl/tad_divider.sv
`default_nettype none
// Restoring divider, three channels in parallel, one quotient bit per cycle.
module tad_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire tad_pkg::tile_job_t job,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_mean_blue,
  output logic [7:0]             out_mean_green,
  output logic [7:0]             out_mean_red,
  output logic [9:0]             out_tile_column,
  output logic [11:0]            out_tile_row,
  output logic                   out_frame_done
);
  import tad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } dstate_t;

  dstate_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] q_r [3];
  logic [SUM_W-1:0] rem_r [3];
  logic [12:0] area_r;
  logic [9:0] col_r;
  logic [11:0] row_r;
  logic last_r;
  logic [SUM_W-1:0] rem_nxt [3];
  logic [SUM_W-1:0] q_nxt [3];
  logic [SUM_W:0] trial [3];

  assign job_ready = (state_r == S_IDLE);

  // one restoring step per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_r[c], q_r[c][SUM_W-1]};
      if (trial[c] >= {8'd0, area_r}) begin
        rem_nxt[c] = SUM_W'(trial[c] - {8'd0, area_r});
        q_nxt[c] = {q_r[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = trial[c][SUM_W-1:0];
        q_nxt[c] = {q_r[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      S_IDLE: if (job_valid) begin
        state_nxt = S_RUN;
        cnt_nxt = 5'(SUM_W - 1);
      end
      S_RUN: begin
        if (cnt_r == 5'd0) state_nxt = S_OUT;
        else cnt_nxt = cnt_r - 5'd1;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && job_valid) begin
      q_r[0] <= job.sum_b;
      q_r[1] <= job.sum_g;
      q_r[2] <= job.sum_r;
      for (int c = 0; c < 3; c++) rem_r[c] <= '0;
      area_r <= job.area;
      col_r <= job.col;
      row_r <= job.row;
      last_r <= job.last;
    end else if (state_r == S_RUN) begin
      for (int c = 0; c < 3; c++) begin
        q_r[c] <= q_nxt[c];
        rem_r[c] <= rem_nxt[c];
      end
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_mean_blue = q_r[0][7:0];
  assign out_mean_green = q_r[1][7:0];
  assign out_mean_red = q_r[2][7:0];
  assign out_tile_column = col_r;
  assign out_tile_row = row_r;
  assign out_frame_done = last_r;
endmodule
`default_nettype wire

// File: rtl/tile_average_downsample_unit.sv
`default_nettype none
// Tile average downsampler.
// Throughput: one pixel per cycle; the divider takes a new tile only when idle,
// once its last result is taken, and a pixel that finishes a tile while the
// divider is busy holds the input off until it is taken.
// Path: out_valid rises after the last pixel of a tile is taken, by way of
// column-sum read and add with divider load, then 20 divider steps.
// Reset: synchronous active low; counters clear, config registers take defaults.
module tile_average_downsample_unit #(
  parameter int MAX_TILE_COLUMNS = 1024,
  parameter int MAX_IMAGE_WIDTH = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [7:0] in_pixel_blue,
  input  wire logic [7:0] in_pixel_green,
  input  wire logic [7:0] in_pixel_red,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_mean_blue,
  output logic [7:0] out_mean_green,
  output logic [7:0] out_mean_red,
  output logic [9:0] out_tile_column,
  output logic [11:0] out_tile_row,
  output logic      out_frame_done,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [tad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tad_pkg::*;

  localparam int CA_W = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
  localparam int MAXH = 4096;

  logic [6:0] tw_cfg_r, th_cfg_r;
  logic [12:0] iw_cfg_r, ih_cfg_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_cfg_r <= 7'd20;
      th_cfg_r <= 7'd15;
      iw_cfg_r <= 13'd640;
      ih_cfg_r <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TILE_W: tw_cfg_r <= cfg_data[6:0];
        REG_TILE_H: th_cfg_r <= cfg_data[6:0];
        REG_IMG_W:  iw_cfg_r <= cfg_data;
        REG_IMG_H:  ih_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated settings
  logic [8:0] tw, th;
  logic [14:0] iw, ih;
  always_comb begin
    tw = {2'd0, tw_cfg_r};
    if (tw < 9'd4) tw = 9'd4;
    if (tw > 9'(MAX_TILE_SIDE)) tw = 9'(MAX_TILE_SIDE);
    th = {2'd0, th_cfg_r};
    if (th < 9'd1) th = 9'd1;
    if (th > 9'(MAX_TILE_SIDE)) th = 9'(MAX_TILE_SIDE);
    iw = {2'd0, iw_cfg_r};
    if (iw < 15'd1) iw = 15'd1;
    if (iw > 15'(MAX_IMAGE_WIDTH)) iw = 15'(MAX_IMAGE_WIDTH);
    ih = {2'd0, ih_cfg_r};
    if (ih < 15'd1) ih = 15'd1;
    if (ih > 15'(MAXH)) ih = 15'(MAXH);
  end

  // position counters
  logic [14:0] px_r, py_r, px_nxt, py_nxt;
  logic [8:0] xt_r, yt_r, xt_nxt, yt_nxt;
  logic [12:0] ci_r, ri_r, ci_nxt, ri_nxt;
  logic [SUM_W-1:0] seg_r [3];
  logic [SUM_W-1:0] seg_nxt [3];
  logic cols_cmp, rows_cmp, last_col, last_row;

  // a tile index is whole while (index + 1) * side fits the image
  logic [23:0] col_span, row_span;
  assign col_span = 24'(ci_r + 13'd1) * 24'(tw);
  assign row_span = 24'(ri_r + 13'd1) * 24'(th);
  assign cols_cmp = (col_span <= 24'(iw)) && (ci_r < 13'(MAX_TILE_COLUMNS));
  assign rows_cmp = (row_span <= 24'(ih));
  assign last_col = (col_span + 24'(tw) > 24'(iw)) ||
                    (ci_r + 13'd1 == 13'(MAX_TILE_COLUMNS));
  assign last_row = (row_span + 24'(th) > 24'(ih));

  // stage 1 of the memory path: pixel that ends a tile row segment
  logic s1_v_r, s1_v_nxt, s1_first_r, s1_fin_r, s1_last_r;
  logic [CA_W-1:0] s1_addr_r;
  logic [SUM_W-1:0] s1_seg_r [3];
  logic [9:0] s1_col_r;
  logic [11:0] s1_row_r;
  logic [12:0] s1_area_r;

  logic [3*SUM_W-1:0] mem [MAX_TILE_COLUMNS];
  logic [3*SUM_W-1:0] rd_r;

  logic job_ready, job_valid, blocked;
  tile_job_t job;

  // stall when a finishing write is pending on a busy divider
  assign blocked = s1_v_r && s1_fin_r && !job_ready;
  assign in_ready = !blocked;

  logic acc, active, seg_end;
  logic [SUM_W-1:0] seg_add [3];
  assign acc = in_valid && in_ready;
  assign active = cols_cmp && rows_cmp;
  assign seg_end = (xt_r + 9'd1 >= tw);
  always_comb begin
    seg_add[0] = seg_r[0] + SUM_W'(in_pixel_blue);
    seg_add[1] = seg_r[1] + SUM_W'(in_pixel_green);
    seg_add[2] = seg_r[2] + SUM_W'(in_pixel_red);
  end

  // raster advance and segment sums
  always_comb begin
    px_nxt = px_r;
    py_nxt = py_r;
    xt_nxt = xt_r;
    yt_nxt = yt_r;
    ci_nxt = ci_r;
    ri_nxt = ri_r;
    for (int c = 0; c < 3; c++) seg_nxt[c] = seg_r[c];
    s1_v_nxt = blocked ? s1_v_r : 1'b0;
    if (acc) begin
      if (active) begin
        for (int c = 0; c < 3; c++) seg_nxt[c] = seg_end ? '0 : seg_add[c];
        if (seg_end) s1_v_nxt = 1'b1;
      end
      if (seg_end) begin
        xt_nxt = '0;
        if (cols_cmp) ci_nxt = ci_r + 13'd1;
      end else xt_nxt = xt_r + 9'd1;
      if (px_r + 15'd1 >= iw) begin
        px_nxt = '0;
        xt_nxt = '0;
        ci_nxt = '0;
        for (int c = 0; c < 3; c++) seg_nxt[c] = '0;
        if (yt_r + 9'd1 >= th) begin
          yt_nxt = '0;
          if (rows_cmp) ri_nxt = ri_r + 13'd1;
        end else yt_nxt = yt_r + 9'd1;
        if (py_r + 15'd1 >= ih) begin
          py_nxt = '0;
          yt_nxt = '0;
          ri_nxt = '0;
        end else py_nxt = py_r + 15'd1;
      end else px_nxt = px_r + 15'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; xt_r <= '0; yt_r <= '0;
      ci_r <= '0; ri_r <= '0;
      for (int c = 0; c < 3; c++) seg_r[c] <= '0;
      s1_v_r <= 1'b0;
    end else begin
      px_r <= px_nxt; py_r <= py_nxt; xt_r <= xt_nxt; yt_r <= yt_nxt;
      ci_r <= ci_nxt; ri_r <= ri_nxt;
      for (int c = 0; c < 3; c++) seg_r[c] <= seg_nxt[c];
      s1_v_r <= s1_v_nxt;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (acc && active && seg_end) begin
      s1_first_r <= (yt_r == 9'd0);
      s1_fin_r <= (yt_r + 9'd1 >= th);
      s1_last_r <= last_col && last_row;
      s1_addr_r <= CA_W'(ci_r);
      s1_col_r <= ci_r[9:0];
      s1_row_r <= ri_r[11:0];
      s1_area_r <= 13'(tw) * 13'(th);
      for (int c = 0; c < 3; c++) s1_seg_r[c] <= seg_add[c];
    end
  end

  // read-modify-write: read on entry, add at stage 1, write back
  always_ff @(posedge clk) begin
    if (acc && active && seg_end) rd_r <= mem[CA_W'(ci_r)];
  end

  logic [SUM_W-1:0] new_sum [3];
  always_comb begin
    for (int c = 0; c < 3; c++)
      new_sum[c] = s1_first_r ? s1_seg_r[c] :
                   rd_r[c*SUM_W +: SUM_W] + s1_seg_r[c];
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && !blocked) mem[s1_addr_r] <= {new_sum[2], new_sum[1], new_sum[0]};
  end

  assign job_valid = s1_v_r && s1_fin_r;
  assign job = '{sum_b: new_sum[0], sum_g: new_sum[1], sum_r: new_sum[2],
                 area: s1_area_r, col: s1_col_r, row: s1_row_r, last: s1_last_r};

  tad_divider u_div (
    .clk(clk), .rst_n(rst_n),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_mean_blue(out_mean_blue), .out_mean_green(out_mean_green),
    .out_mean_red(out_mean_red), .out_tile_column(out_tile_column),
    .out_tile_row(out_tile_row), .out_frame_done(out_frame_done)
  );
endmodule
`default_nettype wire
